// File: rtl/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

	// Result kind; a clear sticky error is held as ST_DATA (no error)
	typedef enum logic [2:0] {
		ST_DATA    = 3'd0,
		ST_OK      = 3'd1,
		ST_BADCHAR = 3'd2,
		ST_BADLEN  = 3'd3,
		ST_BADFMT  = 3'd4
	} status_t;

	localparam logic [15:0] PAD_UNIT = 16'h003D;
	localparam int unsigned MAX_RESULTS = 4;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        has_char;
		logic        end_of_text;
	} item_t;

	// Results caused by one item, packed from entry 0 up
	typedef struct packed {
		logic [2:0]                   cnt;
		logic [MAX_RESULTS-1:0][7:0]  data;
		status_t [MAX_RESULTS-1:0]    st;
	} group_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [15:0] c);
		sextet_t     r;
		logic [15:0] d;
		r = '{ok: 1'b0, val: 6'd0};
		d = 16'd0;
		if (c >= 16'h0041 && c <= 16'h005A) begin
			d = c - 16'h0041;
			r = '{ok: 1'b1, val: d[5:0]};
		end else if (c >= 16'h0061 && c <= 16'h007A) begin
			d = c - 16'h0061 + 16'd26;
			r = '{ok: 1'b1, val: d[5:0]};
		end else if (c >= 16'h0030 && c <= 16'h0039) begin
			d = c - 16'h0030 + 16'd52;
			r = '{ok: 1'b1, val: d[5:0]};
		end else if (c == 16'h002B) begin
			r = '{ok: 1'b1, val: 6'd62};
		end else if (c == 16'h002F) begin
			r = '{ok: 1'b1, val: 6'd63};
		end
		return r;
	endfunction

	function automatic logic is_space(input logic [15:0] c);
		return (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D);
	endfunction

endpackage

`default_nettype wire

// File: rtl/b64d_decode.sv
`default_nettype none

module b64d_decode
	import b64d_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   fire,
	input  wire item_t  item,
	input  wire logic   allow_ws,
	output group_t      grp
);

	logic [2:0][5:0] buf_q, buf_n;
	logic [1:0]      phase_q, phase_n;
	logic [1:0]      pad_q, pad_n;
	logic            saw_q, saw_n;
	status_t         err_q, err_n;

	sextet_t    sx;
	logic       sym, pad;
	logic [5:0] v;
	status_t    fin_st;

	always_comb begin
		sx      = sextet_of(item.code_unit);
		pad     = (item.code_unit == PAD_UNIT);
		sym     = item.has_char && !is_space(item.code_unit);
		v       = pad ? 6'd0 : sx.val;
		buf_n   = buf_q;
		phase_n = phase_q;
		pad_n   = pad_q;
		saw_n   = saw_q | sym;
		err_n   = err_q;
		fin_st  = ST_OK;
		grp     = '0;

		if (sym && err_q == ST_DATA) begin
			if (!pad && !sx.ok) begin
				err_n = ST_BADCHAR;
			end else if (pad_q != 2'd0 && (!pad || phase_q == 2'd0)) begin
				err_n = ST_BADFMT;
			end else if (pad && phase_q < 2'd2) begin
				err_n = ST_BADFMT;
			end else begin
				if (pad) begin
					pad_n = pad_q + 2'd1;
				end
				if (phase_q < 2'd3) begin
					buf_n[phase_q] = v;
					phase_n        = phase_q + 2'd1;
				end else begin
					// complete quartet: emit one to three bytes
					grp.data[0] = {buf_q[0], buf_q[1][5:4]};
					grp.st[0]   = ST_DATA;
					grp.cnt     = 3'd1;
					if (pad_n < 2'd2) begin
						grp.data[1] = {buf_q[1][3:0], buf_q[2][5:2]};
						grp.st[1]   = ST_DATA;
						grp.cnt     = 3'd2;
					end
					if (pad_n == 2'd0) begin
						grp.data[2] = {buf_q[2][1:0], v};
						grp.st[2]   = ST_DATA;
						grp.cnt     = 3'd3;
					end
					phase_n = 2'd0;
				end
			end
		end

		if (item.end_of_text) begin
			if (err_n != ST_DATA) begin
				fin_st = err_n;
			end else if (phase_n != 2'd0) begin
				fin_st = ST_BADLEN;
			end else if (!saw_n) begin
				fin_st = allow_ws ? ST_OK : ST_BADLEN;
			end
			grp.data[grp.cnt[1:0]] = 8'd0;
			grp.st[grp.cnt[1:0]]   = fin_st;
			grp.cnt                = grp.cnt + 3'd1;
			// text closed: back to reset state
			buf_n   = '0;
			phase_n = 2'd0;
			pad_n   = 2'd0;
			saw_n   = 1'b0;
			err_n   = ST_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			phase_q <= 2'd0;
			pad_q   <= 2'd0;
			saw_q   <= 1'b0;
			err_q   <= ST_DATA;
		end else if (fire) begin
			buf_q   <= buf_n;
			phase_q <= phase_n;
			pad_q   <= pad_n;
			saw_q   <= saw_n;
			err_q   <= err_n;
		end
	end

endmodule

`default_nettype wire

// File: rtl/b64d_emit.sv
`default_nettype none

module b64d_emit
	import b64d_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire group_t      grp,
	output logic             can_load,
	output logic             tvalid,
	input  wire logic        tready,
	output logic [7:0]       tdata,
	output logic [2:0]       tuser,
	output logic             tlast
);

	logic [2:0]                  cnt_q;
	logic [1:0]                  rd_q;
	logic [MAX_RESULTS-1:0][7:0] data_q;
	status_t [MAX_RESULTS-1:0]   st_q;
	logic                        take;

	assign tvalid   = (cnt_q != 3'd0);
	assign tlast    = ({1'b0, rd_q} + 3'd1 == cnt_q);
	assign tdata    = data_q[rd_q];
	assign tuser    = st_q[rd_q];
	assign take     = tvalid && tready;
	assign can_load = !tvalid || (take && tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			rd_q  <= 2'd0;
		end else if (load) begin
			cnt_q <= grp.cnt;
			rd_q  <= 2'd0;
		end else if (take) begin
			if (tlast) begin
				cnt_q <= 3'd0;
				rd_q  <= 2'd0;
			end else begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= grp.data;
			st_q   <= grp.st;
		end
	end

endmodule

`default_nettype wire

// File: rtl/base64_stream_decoder_core.sv
// Channel    | Dir | Handshake                     | Payload
// s_axis     | in  | s_axis_tvalid / s_axis_tready | tdata code_unit, tuser has_char,
//            |     |                               | tlast end_of_text
// m_axis     | out | m_axis_tvalid / m_axis_tready | tdata out_byte, tuser status,
//            |     |                               | tlast last_of_run
// cfg        | in  | cfg_valid / cfg_ready         | cfg_data allow_whitespace_only
//
// An item that causes at most one result does not hold up the input register, so such
// items stream at one per cycle while m_axis is ready. An item that causes n results
// (up to four) holds the result group register until all n are taken, one result per
// cycle on m_axis while it is ready; the input register stalls meanwhile.
// arst_n clears all control state and the decoder state; the register resets to 0.
// Back-pressure on m_axis propagates through the group register to s_axis_tready.
`default_nettype none

module base64_stream_decoder_core
	import b64d_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] code_unit
	input  wire logic [0:0]  s_axis_tuser,   // [0] has_char
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
	output logic [2:0]       m_axis_tuser,   // [2:0] status
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_data        // [0] allow_whitespace_only
);

	logic   allow_ws_q;
	logic   v_s1;
	item_t  item_s1;
	logic   advance;
	logic   can_load;
	group_t grp;

	// configuration register: always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_ws_q <= 1'b0;
		end else if (cfg_valid) begin
			allow_ws_q <= cfg_data[0];
		end
	end

	// input register: advance its item into the decoder when the group register frees up
	assign advance       = v_s1 && can_load;
	assign s_axis_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= '{code_unit: s_axis_tdata, has_char: s_axis_tuser[0],
			            end_of_text: s_axis_tlast};
		end
	end

	// decode: quartet state and the group of results for the current item
	b64d_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.item     (item_s1),
		.allow_ws (allow_ws_q),
		.grp      (grp)
	);

	// result group register, drained one transaction per cycle while m_axis is ready
	b64d_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.grp      (grp),
		.can_load (can_load),
		.tvalid   (m_axis_tvalid),
		.tready   (m_axis_tready),
		.tdata    (m_axis_tdata),
		.tuser    (m_axis_tuser),
		.tlast    (m_axis_tlast)
	);

	// a status result always closes its item's run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != 3'(ST_DATA)) |-> m_axis_tlast)
		else $error("status result without tlast");

	// a decoded item with results shows them in the next cycle
	a_group_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && grp.cnt != 3'd0) |=> m_axis_tvalid)
		else $error("result group lost");

	// no group exceeds the result limit
	a_group_size: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (grp.cnt <= 3'(MAX_RESULTS)))
		else $error("result group too large");

	// status code stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= 3'(ST_BADFMT)))
		else $error("undefined status code");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

module testbench;
	import b64d_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam int          LONG_HOLD   = 300;
	localparam logic [15:0] UNIT_SPACE  = 16'h0020;
	localparam logic [15:0] UNIT_TAB    = 16'h0009;
	localparam logic [15:0] UNIT_CR     = 16'h000D;
	localparam logic [15:0] UNIT_PLUS   = 16'h002B;
	localparam logic [15:0] UNIT_SLASH  = 16'h002F;

	typedef struct packed {
		logic [7:0] data;
		status_t    st;
		logic       last;
	} dec_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_data = '0;

	base64_stream_decoder_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	item_t       units_pending[$];
	dec_result_t decoded_due[$];
	int          units_made = 0;
	int          items_in = 0;
	int          mismatches = 0;
	int          cycles = 0;
	int          tx_idle = 0;
	int          rx_idle = 0;
	bit          unit_taken = 1'b0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	// Decoder mirror: register copy and per-text state
	logic       allow_blank_text = 1'b0;
	logic [5:0] quad[3];
	int         quad_fill = 0;
	int         pads_seen = 0;
	logic       seen_symbol = 1'b0;
	status_t    text_err = ST_DATA;

	function automatic logic is_blank(input logic [15:0] c);
		return c == UNIT_SPACE || (c >= UNIT_TAB && c <= UNIT_CR);
	endfunction

	// -1 for anything outside the alphabet
	function automatic int symbol_value(input logic [15:0] c);
		if (c >= "A" && c <= "Z")
			return int'(c) - "A";
		if (c >= "a" && c <= "z")
			return int'(c) - "a" + 26;
		if (c >= "0" && c <= "9")
			return int'(c) - "0" + 52;
		if (c == UNIT_PLUS)
			return 62;
		if (c == UNIT_SLASH)
			return 63;
		return -1;
	endfunction

	function automatic logic [15:0] symbol_unit(input int v);
		if (v < 26)
			return 16'("A" + v);
		if (v < 52)
			return 16'("a" + v - 26);
		if (v < 62)
			return 16'("0" + v - 52);
		return (v == 62) ? UNIT_PLUS : UNIT_SLASH;
	endfunction

	function automatic logic [15:0] blank_unit();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? UNIT_SPACE : 16'(UNIT_TAB + k);
	endfunction

	// Anything from raw 16-bit noise to plausible-looking units
	function automatic logic [15:0] odd_unit();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($urandom_range(0, 127));
			2: return PAD_UNIT;
			default: return blank_unit();
		endcase
	endfunction

	task automatic clear_text();
		quad[0] = '0;
		quad[1] = '0;
		quad[2] = '0;
		quad_fill = 0;
		pads_seen = 0;
		seen_symbol = 1'b0;
		text_err = ST_DATA;
	endtask

	// Work out the results of one accepted item and queue them
	task automatic decode_unit(input item_t it);
		dec_result_t run[$];
		int          v;
		logic        is_pad;
		logic [5:0]  b3;
		status_t     fin;
		if (it.has_char && !is_blank(it.code_unit)) begin
			is_pad = (it.code_unit == PAD_UNIT);
			v = is_pad ? 0 : symbol_value(it.code_unit);
			seen_symbol = 1'b1;
			if (text_err == ST_DATA) begin
				if (v < 0) begin
					text_err = ST_BADCHAR;
				end else if (pads_seen != 0 && (!is_pad || quad_fill == 0)) begin
					text_err = ST_BADFMT;
				end else if (is_pad && quad_fill < 2) begin
					text_err = ST_BADFMT;
				end else begin
					if (is_pad)
						pads_seen++;
					if (quad_fill < 3) begin
						quad[quad_fill] = v[5:0];
						quad_fill++;
					end else begin
						b3 = v[5:0];
						run.push_back('{data: {quad[0], quad[1][5:4]}, st: ST_DATA, last: 1'b0});
						if (pads_seen < 2)
							run.push_back('{data: {quad[1][3:0], quad[2][5:2]}, st: ST_DATA,
								last: 1'b0});
						if (pads_seen < 1)
							run.push_back('{data: {quad[2][1:0], b3}, st: ST_DATA, last: 1'b0});
						quad_fill = 0;
					end
				end
			end
		end
		if (it.end_of_text) begin
			if (text_err != ST_DATA)
				fin = text_err;
			else if (quad_fill != 0)
				fin = ST_BADLEN;
			else if (!seen_symbol)
				fin = allow_blank_text ? ST_OK : ST_BADLEN;
			else
				fin = ST_OK;
			run.push_back('{data: 8'h00, st: fin, last: 1'b0});
			clear_text();
		end
		if (run.size() > 0)
			run[run.size() - 1].last = 1'b1;
		foreach (run[i])
			decoded_due.push_back(run[i]);
	endtask

	task automatic push_unit(input logic [15:0] c, input logic has, input logic eot);
		units_pending.push_back('{code_unit: c, has_char: has, end_of_text: eot});
		if (has || eot)
			units_made++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_unit(16'(s[i]), 1'b1, i == s.len() - 1);
	endtask

	// One text: mostly well formed, some broken, some pure noise
	task automatic add_random_text();
		logic [15:0] txt[$];
		int          kind, nq, npad, close_mode;
		kind = $urandom_range(0, 99);
		nq = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
		npad = (nq == 0) ? 0 : $urandom_range(0, 2);
		for (int i = 0; i < 4 * nq; i++)
			txt.push_back(symbol_unit($urandom_range(0, 63)));
		if (npad > 0)
			txt[txt.size() - 1] = PAD_UNIT;
		if (npad > 1)
			txt[txt.size() - 2] = PAD_UNIT;
		if (kind >= 90) begin
			txt.delete();
			repeat ($urandom_range(0, 6))
				txt.push_back(odd_unit());
		end else if (kind >= 70) begin
			case ($urandom_range(0, 3))
				0: if (txt.size() > 0) txt[$urandom_range(0, txt.size() - 1)] = odd_unit();
				1: if (txt.size() > 0) txt[$urandom_range(0, txt.size() - 1)] = PAD_UNIT;
				2: if (txt.size() > 0) txt.delete(txt.size() - 1);
				default: txt.push_back($urandom_range(0, 1) ? PAD_UNIT
					: symbol_unit($urandom_range(0, 63)));
			endcase
		end
		close_mode = $urandom_range(0, 2);
		if (txt.size() == 0 && close_mode == 0)
			close_mode = 1;
		for (int i = 0; i < txt.size(); i++) begin
			// scatter whitespace and empty items between the symbols
			case ($urandom_range(0, 15))
				0: push_unit(blank_unit(), 1'b1, 1'b0);
				1: push_unit(16'($urandom_range(0, 65535)), 1'b0, 1'b0);
				default: ;
			endcase
			push_unit(txt[i], 1'b1, close_mode == 0 && i == txt.size() - 1);
		end
		if (close_mode == 1)
			push_unit(16'($urandom_range(0, 65535)), 1'b0, 1'b1);
		else if (close_mode == 2)
			push_unit(blank_unit(), 1'b1, 1'b1);
	endtask

	task automatic add_random_texts(input int count);
		int goal;
		goal = units_made + count;
		while (units_made < goal)
			add_random_text();
	endtask

	task automatic drain(input int settle);
		while (units_pending.size() != 0 || decoded_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_allow(input logic v);
		drain(8);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		allow_blank_text = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sender: hold the offered item until its transaction completes
	always @(negedge clk) begin
		if (!s_axis_tvalid || unit_taken) begin
			unit_taken = 1'b0;
			if (arst_n && units_pending.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= units_pending[0].code_unit;
				s_axis_tuser <= units_pending[0].has_char;
				s_axis_tlast <= units_pending[0].end_of_text;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off to fill the block
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && items_in >= 60) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	always @(posedge clk) begin : watch
		dec_result_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{data: m_axis_tdata, st: status_t'(m_axis_tuser), last: m_axis_tlast};
				if (decoded_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: byte %h status %0d last %b",
							got.data, got.st, got.last);
				end else begin
					want = decoded_due.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected byte %h status %0d last %b, got byte %h status %0d last %b",
								want.data, want.st, want.last, got.data, got.st, got.last);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				decode_unit(units_pending.pop_front());
				items_in++;
				unit_taken = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		clear_text();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// register at its reset value: blank texts are bad length
		tx_idle = 34;
		rx_idle = 49;
		push_unit(16'h0000, 1'b0, 1'b0);
		push_unit(16'hFFFF, 1'b0, 1'b1);
		push_text("TWFu");
		push_text("TQ==");
		push_text(" TWE=\n");
		push_text("=");
		push_text("TQ=A");
		push_text("TWF");
		push_unit(16'hFFFF, 1'b1, 1'b1);
		push_unit(16'h0080, 1'b1, 1'b0);
		push_text("9=");
		add_random_texts(135);

		write_allow(1'b1);
		tx_idle = 49;
		rx_idle = 34;
		push_unit(16'h1234, 1'b0, 1'b1);
		push_unit(UNIT_SPACE, 1'b1, 1'b0);
		for (int c = UNIT_TAB; c <= UNIT_CR; c++)
			push_unit(16'(c), 1'b1, c == UNIT_CR);
		add_random_texts(135);

		write_allow(1'b0);
		tx_idle = 0;
		rx_idle = 0;
		add_random_texts(120);

		drain(20);
		if (mismatches == 0 && decoded_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
